### sv/fiber_pool_priority_queues_defines.svh
// Assertion macros shared by the fiber pool RTL.
`ifndef FIBER_POOL_PRIORITY_QUEUES_DEFINES_SVH
`define FIBER_POOL_PRIORITY_QUEUES_DEFINES_SVH

`ifndef SYNTHESIS

// Checks a property at every clock edge outside reset.
`define FPQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("fiber pool check failed");

// Checks that a condition is followed by a consequence in the next cycle.
`define FPQ_ASSERT_NEXT(lbl, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error("fiber pool sequence check failed");

`else

`define FPQ_ASSERT_ALWAYS(lbl, expr)
`define FPQ_ASSERT_NEXT(lbl, cond, conseq)

`endif

`endif

### sv/fpq_pkg.sv
// Shared types and constants of the fiber pool priority queues.
package fpq_pkg;

    // Operation codes carried by the opcode field.
    typedef enum logic [1:0] {
        OP_CREATE = 2'd0,
        OP_ENABLE = 2'd1,
        OP_RETURN = 2'd2,
        OP_TAKE   = 2'd3
    } opcode_t;

    localparam int PRIO_LEVELS = 5;
    localparam int QUEUE_COUNT = PRIO_LEVELS + 1;
    localparam int QID_W       = 3;
    localparam int PRIO_W      = 3;

    // Queue zero holds idle slots; queue one plus p holds priority p.
    localparam logic [QID_W-1:0] IDLE_QUEUE = 3'd0;

    // One command to the shared queue unit.
    typedef struct packed {
        logic             push;
        logic             pop;
        logic [QID_W-1:0] qid;
    } qcmd_t;

endpackage

### sv/fpq_queues.sv
// Shared queue unit: six circular FIFOs in one memory, one push or pop per cycle.
`include "fiber_pool_priority_queues_defines.svh"

module fpq_queues #(
    parameter int NUM_SLOTS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fpq_pkg::qcmd_t                      cmd,
    input  logic [$clog2(NUM_SLOTS)-1:0]        push_data,
    output logic [$clog2(NUM_SLOTS)-1:0]        pop_data,
    output logic [fpq_pkg::QUEUE_COUNT-1:0]     nonempty,
    output logic [fpq_pkg::QUEUE_COUNT-1:0]     full
);

    localparam int S      = $clog2(NUM_SLOTS);
    localparam int FILL_W = $clog2(NUM_SLOTS + 1);
    localparam int DEPTH  = fpq_pkg::QUEUE_COUNT << S;

    logic [S-1:0]      queue_mem [DEPTH];
    logic [S-1:0]      pop_data_reg;
    logic [S-1:0]      head_reg [fpq_pkg::QUEUE_COUNT];
    logic [S-1:0]      tail_reg [fpq_pkg::QUEUE_COUNT];
    logic [FILL_W-1:0] fill_reg [fpq_pkg::QUEUE_COUNT];
    logic              do_push;
    logic              do_pop;

    // Pointer step with wrap at the pool size.
    function automatic logic [S-1:0] advance(input logic [S-1:0] pos);
        logic [S-1:0] res;
        if (pos == S'(NUM_SLOTS - 1)) begin
            res = '0;
        end else begin
            res = pos + 1'b1;
        end
        return res;
    endfunction

    // Per-queue status flags.
    always_comb
    begin
        for (int i = 0; i < fpq_pkg::QUEUE_COUNT; i++) begin
            nonempty[i] = (fill_reg[i] != '0);
            full[i]     = (fill_reg[i] == FILL_W'(NUM_SLOTS));
        end
    end

    assign do_push  = cmd.push && !full[cmd.qid];
    assign do_pop   = cmd.pop && nonempty[cmd.qid];
    assign pop_data = pop_data_reg;

    // Entry memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            queue_mem[{cmd.qid, tail_reg[cmd.qid]}] <= push_data;
        end
        if (do_pop) begin
            pop_data_reg <= queue_mem[{cmd.qid, head_reg[cmd.qid]}];
        end
    end

    // Head, tail and fill count of each queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < fpq_pkg::QUEUE_COUNT; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else begin
            if (do_push) begin
                tail_reg[cmd.qid] <= advance(tail_reg[cmd.qid]);
                fill_reg[cmd.qid] <= fill_reg[cmd.qid] + 1'b1;
            end else if (do_pop) begin
                head_reg[cmd.qid] <= advance(head_reg[cmd.qid]);
                fill_reg[cmd.qid] <= fill_reg[cmd.qid] - 1'b1;
            end
        end
    end

    `FPQ_ASSERT_ALWAYS(a_no_push_and_pop, !(cmd.push && cmd.pop))
    `FPQ_ASSERT_ALWAYS(a_qid_in_range,
        !(cmd.push || cmd.pop) || (cmd.qid < fpq_pkg::QID_W'(fpq_pkg::QUEUE_COUNT)))

endmodule

### sv/fiber_pool_priority_queues.sv
// Create ends in ST_EXEC, enable and return in ST_ROUTE, take in ST_TAKE_OUT after ST_TAKE_RD; ST_EXEC if empty.
// One command is in flight at a time; busy stays high until its done beat is issued,
// and a new start may be accepted in the cycle that done is high.
// The sequence is set by the single port of the shared queue memory and registered reads.
// Reset empties all queues and the slot count at once; there is no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle with done.
`include "fiber_pool_priority_queues_defines.svh"

module fiber_pool_priority_queues #(
    parameter int NUM_SLOTS   = 64,
    parameter int HANDLE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  slot_id,
    input  logic        has_job,
    input  logic [31:0] job_handle,
    input  logic [2:0]  prio_level,
    output logic        done,
    output logic        ok,
    output logic [5:0]  out_slot,
    output logic        out_has_job,
    output logic [31:0] out_job_handle,
    output logic [2:0]  out_prio_level
);

    localparam int S  = $clog2(NUM_SLOTS);
    localparam int UW = $clog2(NUM_SLOTS + 1);
    localparam int HW = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ROUTE,
        ST_TAKE_RD,
        ST_TAKE_OUT
    } state_t;

    typedef struct packed {
        logic                          has_job;
        logic [HW-1:0]                 handle;
        logic [fpq_pkg::PRIO_W-1:0]    prio;
    } desc_t;

    state_t                        state_reg;
    fpq_pkg::opcode_t              op_reg;
    logic [5:0]                    slot_id_reg;
    desc_t                         din_reg;
    logic [UW-1:0]                 used_reg;
    logic                          done_reg;
    logic                          ok_reg;
    logic [5:0]                    out_slot_reg;
    logic                          out_has_job_reg;
    logic [31:0]                   out_handle_reg;
    logic [2:0]                    out_prio_reg;

    desc_t                         desc_mem [NUM_SLOTS];
    desc_t                         desc_rd_reg;

    fpq_pkg::qcmd_t                qcmd;
    logic [S-1:0]                  push_data;
    logic [S-1:0]                  pop_data;
    logic [fpq_pkg::QUEUE_COUNT-1:0] q_nonempty;
    logic [fpq_pkg::QUEUE_COUNT-1:0] q_full;

    logic                          pool_left;
    logic                          slot_in_range;
    logic [S-1:0]                  slot_in;
    logic                          take_hit;
    logic [fpq_pkg::QID_W-1:0]     take_q;
    logic [S-1:0]                  route_slot;
    logic                          route_valid;
    logic [fpq_pkg::QID_W-1:0]     route_q;
    logic                          route_push;
    logic                          desc_we;
    logic [S-1:0]                  desc_waddr;
    desc_t                         desc_wdata;

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign out_slot       = out_slot_reg;
    assign out_has_job    = out_has_job_reg;
    assign out_job_handle = out_handle_reg;
    assign out_prio_level = out_prio_reg;

    // Decode of the latched command.
    assign pool_left     = (used_reg < UW'(NUM_SLOTS));
    assign slot_in_range = ({26'd0, slot_id_reg} < 32'(NUM_SLOTS));
    assign slot_in       = S'(32'(slot_id_reg));

    // Highest nonempty priority queue.
    always_comb
    begin
        take_hit = 1'b0;
        take_q   = fpq_pkg::IDLE_QUEUE;
        for (int q = fpq_pkg::QUEUE_COUNT - 1; q >= 1; q--) begin
            if (q_nonempty[q]) begin
                take_hit = 1'b1;
                take_q   = fpq_pkg::QID_W'(q);
            end
        end
    end

    // Routing target of the stored descriptor.
    always_comb
    begin
        route_slot  = (op_reg == fpq_pkg::OP_ENABLE) ? pop_data : slot_in;
        route_valid = !din_reg.has_job ||
                      (din_reg.prio < fpq_pkg::PRIO_W'(fpq_pkg::PRIO_LEVELS));
        route_q     = din_reg.has_job ? (din_reg.prio + 3'd1) : fpq_pkg::IDLE_QUEUE;
        route_push  = route_valid && !q_full[route_q];
    end

    // Commands to the queue unit and descriptor writes for each step.
    always_comb
    begin
        qcmd       = '0;
        push_data  = '0;
        desc_we    = 1'b0;
        desc_waddr = '0;
        desc_wdata = '0;
        unique case (state_reg)
            ST_EXEC:
            begin
                unique case (op_reg)
                    fpq_pkg::OP_CREATE:
                    begin
                        if (pool_left) begin
                            desc_we    = 1'b1;
                            desc_waddr = S'(used_reg);
                            qcmd.push  = !q_full[fpq_pkg::IDLE_QUEUE];
                            qcmd.qid   = fpq_pkg::IDLE_QUEUE;
                            push_data  = S'(used_reg);
                        end
                    end
                    fpq_pkg::OP_ENABLE:
                    begin
                        qcmd.pop = q_nonempty[fpq_pkg::IDLE_QUEUE];
                        qcmd.qid = fpq_pkg::IDLE_QUEUE;
                    end
                    fpq_pkg::OP_RETURN:
                    begin
                        qcmd = '0;
                    end
                    fpq_pkg::OP_TAKE:
                    begin
                        qcmd.pop = take_hit;
                        qcmd.qid = take_q;
                    end
                endcase
            end
            ST_ROUTE:
            begin
                desc_we    = 1'b1;
                desc_waddr = route_slot;
                desc_wdata = din_reg;
                qcmd.push  = route_push;
                qcmd.qid   = route_q;
                push_data  = route_slot;
            end
            ST_IDLE, ST_TAKE_RD, ST_TAKE_OUT:
            begin
                qcmd = '0;
            end
            default:
            begin
                qcmd = '0;
            end
        endcase
    end

    // Descriptor memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (desc_we) begin
            desc_mem[desc_waddr] <= desc_wdata;
        end
        if (state_reg == ST_TAKE_RD) begin
            desc_rd_reg <= desc_mem[pop_data];
        end
    end

    // Sequencer, latched command and registered results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg       <= ST_IDLE;
            op_reg          <= fpq_pkg::OP_CREATE;
            slot_id_reg     <= '0;
            din_reg         <= '0;
            used_reg        <= '0;
            done_reg        <= 1'b0;
            ok_reg          <= 1'b0;
            out_slot_reg    <= '0;
            out_has_job_reg <= 1'b0;
            out_handle_reg  <= '0;
            out_prio_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start) begin
                        op_reg          <= fpq_pkg::opcode_t'(opcode);
                        slot_id_reg     <= slot_id;
                        din_reg.has_job <= has_job;
                        din_reg.handle  <= job_handle[HW-1:0];
                        din_reg.prio    <= prio_level;
                        state_reg       <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    ok_reg          <= 1'b0;
                    out_slot_reg    <= '0;
                    out_has_job_reg <= 1'b0;
                    out_handle_reg  <= '0;
                    out_prio_reg    <= '0;
                    unique case (op_reg)
                        fpq_pkg::OP_CREATE:
                        begin
                            if (pool_left) begin
                                used_reg <= used_reg + 1'b1;
                                if (!q_full[fpq_pkg::IDLE_QUEUE]) begin
                                    ok_reg       <= 1'b1;
                                    out_slot_reg <= 6'(32'(used_reg));
                                end
                            end
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        fpq_pkg::OP_ENABLE:
                        begin
                            if (q_nonempty[fpq_pkg::IDLE_QUEUE]) begin
                                state_reg <= ST_ROUTE;
                            end else begin
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                        end
                        fpq_pkg::OP_RETURN:
                        begin
                            if (slot_in_range) begin
                                state_reg <= ST_ROUTE;
                            end else begin
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                        end
                        fpq_pkg::OP_TAKE:
                        begin
                            if (take_hit) begin
                                state_reg <= ST_TAKE_RD;
                            end else begin
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                        end
                    endcase
                end
                ST_ROUTE:
                begin
                    // An enabled slot reports success even when routing drops it.
                    if (op_reg == fpq_pkg::OP_ENABLE) begin
                        ok_reg       <= 1'b1;
                        out_slot_reg <= 6'(32'(pop_data));
                    end else begin
                        ok_reg <= route_push;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                ST_TAKE_RD:
                begin
                    out_slot_reg <= 6'(32'(pop_data));
                    state_reg    <= ST_TAKE_OUT;
                end
                ST_TAKE_OUT:
                begin
                    ok_reg          <= 1'b1;
                    out_has_job_reg <= desc_rd_reg.has_job;
                    out_handle_reg  <= 32'(desc_rd_reg.handle);
                    out_prio_reg    <= desc_rd_reg.prio;
                    done_reg        <= 1'b1;
                    state_reg       <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    fpq_queues #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_queues (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (qcmd),
        .push_data (push_data),
        .pop_data  (pop_data),
        .nonempty  (q_nonempty),
        .full      (q_full)
    );

    `FPQ_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy)
    `FPQ_ASSERT_NEXT(a_no_done_after_accept, start && !busy, !done)
    `FPQ_ASSERT_ALWAYS(a_done_when_idle, !done || !busy || (state_reg == ST_EXEC))
    `FPQ_ASSERT_ALWAYS(a_used_bounded, used_reg <= UW'(NUM_SLOTS))

endmodule

### tb/sv/fiber_pool_priority_queues_checker.sv
// Checker that follows the slot pool command stream and compares every result beat.
`timescale 1ns / 100ps

module fiber_pool_priority_queues_checker #(
    parameter int NUM_SLOTS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  opcode,
    input  logic [5:0]  slot_id,
    input  logic        has_job,
    input  logic [31:0] job_handle,
    input  logic [2:0]  prio_level,
    input  logic        done,
    input  logic        ok,
    input  logic [5:0]  out_slot,
    input  logic        out_has_job,
    input  logic [31:0] out_job_handle,
    input  logic [2:0]  out_prio_level,
    output int          pending,
    output int          fail_count
);

    // One result beat as the block reports it.
    typedef struct packed {
        logic        ok;
        logic [5:0]  slot;
        logic        has_job;
        logic [31:0] handle;
        logic [2:0]  prio;
    } pool_result_t;

    // Job descriptor kept per slot.
    typedef struct packed {
        logic        has_job;
        logic [31:0] handle;
        logic [2:0]  prio;
    } job_desc_t;

    // Shadow copy of the pool: descriptors, slot count and the six ring buffers.
    job_desc_t    slot_desc  [NUM_SLOTS];
    int           slots_created;
    int           ring_mem   [fpq_pkg::QUEUE_COUNT][NUM_SLOTS];
    int           ring_head  [fpq_pkg::QUEUE_COUNT];
    int           ring_tail  [fpq_pkg::QUEUE_COUNT];
    int           ring_fill  [fpq_pkg::QUEUE_COUNT];
    pool_result_t awaited_results [$];

    function automatic int ring_next(int pos);
        return (pos + 1 >= NUM_SLOTS) ? 0 : pos + 1;
    endfunction

    // A push to a full ring is dropped.
    function automatic bit ring_push(int q, int slot);
        if (ring_fill[q] >= NUM_SLOTS)
            return 1'b0;
        ring_mem[q][ring_tail[q]] = slot;
        ring_tail[q] = ring_next(ring_tail[q]);
        ring_fill[q]++;
        return 1'b1;
    endfunction

    function automatic bit ring_pop(int q, output int slot);
        slot = 0;
        if (ring_fill[q] == 0)
            return 1'b0;
        slot = ring_mem[q][ring_head[q]];
        ring_head[q] = ring_next(ring_head[q]);
        ring_fill[q]--;
        return 1'b1;
    endfunction

    // Slots without a job go idle; a job with an undefined priority goes nowhere.
    function automatic bit route_slot(int slot);
        if (!slot_desc[slot].has_job)
            return ring_push(int'(fpq_pkg::IDLE_QUEUE), slot);
        if (slot_desc[slot].prio >= fpq_pkg::PRIO_LEVELS)
            return 1'b0;
        return ring_push(1 + int'(slot_desc[slot].prio), slot);
    endfunction

    // Applies one command to the shadow pool and returns the beat it must produce.
    function automatic pool_result_t pool_outcome(fpq_pkg::opcode_t op, logic [5:0] sid,
                                                  job_desc_t desc);
        pool_result_t res;
        int           slot;
        int           q;
        res = '0;
        slot = 0;
        case (op)
            fpq_pkg::OP_CREATE:
            begin
                if (slots_created < NUM_SLOTS) begin
                    slot = slots_created;
                    slots_created++;
                    slot_desc[slot] = '0;
                    res.ok = ring_push(int'(fpq_pkg::IDLE_QUEUE), slot);
                    if (!res.ok)
                        slot = 0;
                end
            end
            fpq_pkg::OP_ENABLE:
            begin
                // Once a slot is popped the enable succeeds even if routing fails.
                if (ring_pop(int'(fpq_pkg::IDLE_QUEUE), slot)) begin
                    slot_desc[slot] = desc;
                    void'(route_slot(slot));
                    res.ok = 1'b1;
                end
            end
            fpq_pkg::OP_RETURN:
            begin
                if (int'(sid) < NUM_SLOTS) begin
                    slot_desc[sid] = desc;
                    res.ok = route_slot(int'(sid));
                end
            end
            default:
            begin
                // Strict priority: the critical ring is searched first.
                for (q = 1; q < fpq_pkg::QUEUE_COUNT; q++) begin
                    if (ring_pop(q, slot)) begin
                        res.ok = 1'b1;
                        res.has_job = slot_desc[slot].has_job;
                        res.handle = slot_desc[slot].handle;
                        res.prio = slot_desc[slot].prio;
                        break;
                    end
                end
            end
        endcase
        res.slot = slot[5:0];
        return res;
    endfunction

    // Result beats are checked before the command beat of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin : track
        pool_result_t got;
        pool_result_t want;
        job_desc_t    desc;
        int           i;
        if (!rst_n) begin
            for (i = 0; i < NUM_SLOTS; i++)
                slot_desc[i] = '0;
            for (i = 0; i < fpq_pkg::QUEUE_COUNT; i++) begin
                ring_head[i] = 0;
                ring_tail[i] = 0;
                ring_fill[i] = 0;
            end
            slots_created = 0;
            awaited_results.delete();
            pending <= 0;
            fail_count <= 0;
        end else begin
            if (done) begin
                got = '{ok, out_slot, out_has_job, out_job_handle, out_prio_level};
                if (awaited_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("%0t: result beat with no command outstanding", $realtime);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"%0t: mismatch: expected ok=%0b slot=%0d job=%0b ",
                                      "handle=%h prio=%0d, got ok=%0b slot=%0d job=%0b ",
                                      "handle=%h prio=%0d"}, $realtime,
                                     want.ok, want.slot, want.has_job, want.handle,
                                     want.prio, got.ok, got.slot, got.has_job,
                                     got.handle, got.prio);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (start && !busy) begin
                desc = '{has_job, job_handle, prio_level};
                awaited_results.push_back(
                    pool_outcome(fpq_pkg::opcode_t'(opcode), slot_id, desc));
            end
            pending <= awaited_results.size();
        end
    end

endmodule

### tb/sv/fiber_pool_priority_queues_tb.sv
// Top of the slot pool testbench: command stimulus, reset, clock and the verdict.
`timescale 1ns / 100ps

module fiber_pool_priority_queues_tb;

    localparam int NUM_SLOTS   = 64;
    localparam int RANDOM_RUN  = 150;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [5:0]  slot_id;
    logic        has_job;
    logic [31:0] job_handle;
    logic [2:0]  prio_level;
    logic        done;
    logic        ok;
    logic [5:0]  out_slot;
    logic        out_has_job;
    logic [31:0] out_job_handle;
    logic [2:0]  out_prio_level;
    int          pending;
    int          fail_count;
    int          idle_pct;
    int          creates_sent;

    fiber_pool_priority_queues #(
        .NUM_SLOTS   (NUM_SLOTS),
        .HANDLE_BITS (32)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .slot_id        (slot_id),
        .has_job        (has_job),
        .job_handle     (job_handle),
        .prio_level     (prio_level),
        .done           (done),
        .ok             (ok),
        .out_slot       (out_slot),
        .out_has_job    (out_has_job),
        .out_job_handle (out_job_handle),
        .out_prio_level (out_prio_level)
    );

    fiber_pool_priority_queues_checker #(
        .NUM_SLOTS (NUM_SLOTS)
    ) pool_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .slot_id        (slot_id),
        .has_job        (has_job),
        .job_handle     (job_handle),
        .prio_level     (prio_level),
        .done           (done),
        .ok             (ok),
        .out_slot       (out_slot),
        .out_has_job    (out_has_job),
        .out_job_handle (out_job_handle),
        .out_prio_level (out_prio_level),
        .pending        (pending),
        .fail_count     (fail_count)
    );

    // Free-running clock, 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Drives one command beat, with a random gap first, and holds it until accepted.
    task automatic issue_cmd(fpq_pkg::opcode_t op, logic [5:0] sid, logic hj,
                             logic [31:0] handle, logic [2:0] prio);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        opcode     <= op;
        slot_id    <= sid;
        has_job    <= hj;
        job_handle <= handle;
        prio_level <= prio;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (op == fpq_pkg::OP_CREATE && creates_sent < NUM_SLOTS)
            creates_sent++;
    endtask

    // Holds off new commands until every outstanding result beat has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly slots that exist, now and then any slot number.
    function automatic logic [5:0] pick_slot();
        if (creates_sent > 0 && $urandom_range(9) < 8)
            return 6'($urandom_range(creates_sent - 1));
        return 6'($urandom_range(63));
    endfunction

    // Mostly defined priorities, sometimes the undefined codes.
    function automatic logic [2:0] pick_prio();
        if ($urandom_range(9) < 9)
            return 3'($urandom_range(fpq_pkg::PRIO_LEVELS - 1));
        return 3'($urandom_range(7));
    endfunction

    // Overfills one ring with returns, then drains it again.
    task automatic flood_queue(logic hj, logic [2:0] prio);
        int n;
        for (n = 0; n < NUM_SLOTS + 2; n++)
            issue_cmd(fpq_pkg::OP_RETURN, pick_slot(), hj, $urandom, prio);
        issue_cmd(fpq_pkg::OP_CREATE, pick_slot(), 1'($urandom), $urandom, pick_prio());
        for (n = 0; n < NUM_SLOTS + 2; n++) begin
            if (hj)
                issue_cmd(fpq_pkg::OP_TAKE, pick_slot(), 1'($urandom), $urandom,
                          pick_prio());
            else
                issue_cmd(fpq_pkg::OP_ENABLE, pick_slot(), 1'b1, $urandom,
                          3'($urandom_range(fpq_pkg::PRIO_LEVELS - 1)));
        end
    endtask

    // A random command with a bias toward sensible traffic.
    task automatic random_cmd();
        int               pick;
        fpq_pkg::opcode_t op;
        pick = $urandom_range(99);
        if (pick < 15)
            op = fpq_pkg::OP_CREATE;
        else if (pick < 40)
            op = fpq_pkg::OP_ENABLE;
        else if (pick < 70)
            op = fpq_pkg::OP_RETURN;
        else
            op = fpq_pkg::OP_TAKE;
        issue_cmd(op, pick_slot(), $urandom_range(9) < 8, $urandom, pick_prio());
    endtask

    // Stimulus: reset, directed commands, three random phases, then the verdict.
    initial
    begin
        int phase;
        int n;
        int waited;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        opcode       <= fpq_pkg::OP_CREATE;
        slot_id      <= '0;
        has_job      <= 1'b0;
        job_handle   <= '0;
        prio_level   <= '0;
        idle_pct     = 20;
        creates_sent = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pool: nothing to take and nothing to enable.
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'h1, 3'd1);
        issue_cmd(fpq_pkg::OP_CREATE, 6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_CREATE, 6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_CREATE, 6'd0, 1'b0, 32'h0, 3'd0);
        // Enables at both priority extremes, one with an undefined priority, and one with no idle slot left.
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'hFFFF_FFFF, 3'd4);
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'h0000_0000, 3'd0);
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'h1234_5678, 3'd5);
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'h8765_4321, 3'd2);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        // Returns: a never-created slot, an undefined priority, a slot queued twice, a slot with no job.
        issue_cmd(fpq_pkg::OP_RETURN, 6'd63, 1'b1, 32'hA5A5_A5A5, 3'd2);
        issue_cmd(fpq_pkg::OP_RETURN, 6'd0,  1'b1, 32'hDEAD_BEEF, 3'd7);
        issue_cmd(fpq_pkg::OP_RETURN, 6'd1,  1'b1, 32'h5A5A_5A5A, 3'd3);
        issue_cmd(fpq_pkg::OP_RETURN, 6'd1,  1'b1, 32'h5A5A_5A5A, 3'd3);
        issue_cmd(fpq_pkg::OP_RETURN, 6'd2,  1'b0, 32'hFFFF_FFFF, 3'd6);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);
        issue_cmd(fpq_pkg::OP_ENABLE, 6'd0, 1'b1, 32'h0F0F_0F0F, 3'd1);
        issue_cmd(fpq_pkg::OP_TAKE,   6'd0, 1'b0, 32'h0, 3'd0);

        // Sender gaps change phase by phase (35, 66, then 0 percent idle); each phase starts from a quiet block.
        for (phase = 0; phase < 3; phase++) begin
            drain_results();
            idle_pct = (phase == 0) ? 35 : (phase == 1) ? 66 : 0;
            if (phase == 0)
                flood_queue(1'b0, 3'($urandom_range(7)));
            else
                flood_queue(1'b1, 3'($urandom_range(fpq_pkg::PRIO_LEVELS - 1)));
            for (n = 0; n < RANDOM_RUN; n++)
                random_cmd();
        end

        // Let the last result beats arrive, then give the verdict.
        start <= 1'b0;
        waited = 0;
        @(posedge clk);
        while (pending != 0 && waited < 1000) begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
